FILE: design/ptc_pkg.sv
// Shared types, operation codes and helpers for the pressure/temperature
// compensation block. No dependencies.
`default_nettype none

package ptc_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CFG_OVERSAMPLING = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_AC1_AC2      = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_AC3_AC4      = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_AC5_AC6      = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_B1_B2        = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_MC_MD        = 3'd5;

  localparam logic MODE_TEMPERATURE = 1'b0;
  localparam logic MODE_PRESSURE    = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [23:0] raw_reading;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] value;
    logic               divide_fault;
  } out_item_t;

  // datapath operations, one per controller step
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_T_X1,
    OP_T_DEN,
    OP_T_FIN,
    OP_P_B6,
    OP_P_SQ,
    OP_P_X1A,
    OP_P_X3A,
    OP_P_B3,
    OP_P_X1B,
    OP_P_X3B,
    OP_P_B4,
    OP_P_B7,
    OP_P_P,
    OP_P_T,
    OP_P_X1C,
    OP_P_FIN,
    OP_P_FLT
  } op_t;

  typedef struct packed {
    op_t op;
  } ptc_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_done;
    logic out_busy;
  } ptc_status_t;

  // arithmetic right shift of a 32-bit pattern
  function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] s);
    return 32'($signed(v) >>> s);
  endfunction

endpackage

`default_nettype wire

FILE: design/ptc_div.sv
// Unsigned 32/32 restoring divider, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none

module ptc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [31:0]      quo
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh = {rem, quo[31]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign done   = busy && (cnt == 5'd31);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (busy) begin
      // subtract where it fits, shift the quotient bit in
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/ptc_ctrl.sv
// Step sequencer for the compensation datapath.
// Depends on ptc_pkg.
`default_nettype none

module ptc_ctrl
  import ptc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_mode,
  output logic             in_stall,
  input  wire ptc_status_t status,
  output ptc_cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_T_X1, S_T_DEN, S_T_WAIT, S_T_FIN,
    S_P_B6, S_P_SQ, S_P_X1A, S_P_X3A, S_P_B3, S_P_X1B, S_P_X3B, S_P_B4,
    S_P_B7, S_P_WAIT, S_P_P, S_P_T, S_P_X1C, S_P_FIN, S_P_FLT
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE:   if (in_valid) cmd.op = OP_LOAD;
      S_T_X1:   cmd.op = OP_T_X1;
      S_T_DEN:  cmd.op = OP_T_DEN;
      S_T_WAIT: cmd.op = OP_NONE;
      S_T_FIN:  if (!status.out_busy) cmd.op = OP_T_FIN;
      S_P_B6:   cmd.op = OP_P_B6;
      S_P_SQ:   cmd.op = OP_P_SQ;
      S_P_X1A:  cmd.op = OP_P_X1A;
      S_P_X3A:  cmd.op = OP_P_X3A;
      S_P_B3:   cmd.op = OP_P_B3;
      S_P_X1B:  cmd.op = OP_P_X1B;
      S_P_X3B:  cmd.op = OP_P_X3B;
      S_P_B4:   cmd.op = OP_P_B4;
      S_P_B7:   cmd.op = OP_P_B7;
      S_P_WAIT: cmd.op = OP_NONE;
      S_P_P:    cmd.op = OP_P_P;
      S_P_T:    cmd.op = OP_P_T;
      S_P_X1C:  cmd.op = OP_P_X1C;
      S_P_FIN:  if (!status.out_busy) cmd.op = OP_P_FIN;
      S_P_FLT:  if (!status.out_busy) cmd.op = OP_P_FLT;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= (in_mode == MODE_PRESSURE) ? S_P_B6 : S_T_X1;
        S_T_X1:   state <= S_T_DEN;
        S_T_DEN:  state <= status.den_zero ? S_T_FIN : S_T_WAIT;
        S_T_WAIT: if (status.div_done) state <= S_T_FIN;
        S_T_FIN:  if (!status.out_busy) state <= S_IDLE;
        S_P_B6:   state <= S_P_SQ;
        S_P_SQ:   state <= S_P_X1A;
        S_P_X1A:  state <= S_P_X3A;
        S_P_X3A:  state <= S_P_B3;
        S_P_B3:   state <= S_P_X1B;
        S_P_X1B:  state <= S_P_X3B;
        S_P_X3B:  state <= S_P_B4;
        S_P_B4:   state <= S_P_B7;
        S_P_B7:   state <= status.den_zero ? S_P_FLT : S_P_WAIT;
        S_P_WAIT: if (status.div_done) state <= S_P_P;
        S_P_P:    state <= S_P_T;
        S_P_T:    state <= S_P_X1C;
        S_P_X1C:  state <= S_P_FIN;
        S_P_FIN:  if (!status.out_busy) state <= S_IDLE;
        S_P_FLT:  if (!status.out_busy) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/ptc_datapath.sv
// Compensation datapath: configuration registers, one shared multiplier,
// the divider and the result register. Depends on ptc_pkg and ptc_div.
`default_nettype none

module ptc_datapath
  import ptc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write_en,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output out_item_t                     out_data,
  input  wire ptc_cmd_t                 cmd,
  output ptc_status_t                   status
);

  logic [1:0]  oss;
  logic [31:0] c_ac1_ac2, c_ac3_ac4, c_ac5_ac6, c_b1_b2, c_mc_md;

  logic        mode_r;
  logic [23:0] raw_r;
  logic [31:0] last_b5, b6, sq, r1, up, b3, b4, p;
  logic        neg, tfault, post_shift;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] den_t, num_t, div_num, div_den, quo, x2_t, b5_t;
  logic        div_start, div_done;

  assign ac1 = {{16{c_ac1_ac2[31]}}, c_ac1_ac2[31:16]};
  assign ac2 = {{16{c_ac1_ac2[15]}}, c_ac1_ac2[15:0]};
  assign ac3 = {{16{c_ac3_ac4[31]}}, c_ac3_ac4[31:16]};
  assign ac4 = {16'd0, c_ac3_ac4[15:0]};
  assign ac5 = {16'd0, c_ac5_ac6[31:16]};
  assign ac6 = {16'd0, c_ac5_ac6[15:0]};
  assign b1  = {{16{c_b1_b2[31]}}, c_b1_b2[31:16]};
  assign b2  = {{16{c_b1_b2[15]}}, c_b1_b2[15:0]};
  assign mc  = {{16{c_mc_md[31]}}, c_mc_md[31:16]};
  assign md  = {{16{c_mc_md[15]}}, c_mc_md[15:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      oss       <= '0;
      c_ac1_ac2 <= '0;
      c_ac3_ac4 <= '0;
      c_ac5_ac6 <= '0;
      c_b1_b2   <= '0;
      c_mc_md   <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_OVERSAMPLING: oss       <= cfg_data[1:0];
        CFG_AC1_AC2:      c_ac1_ac2 <= cfg_data;
        CFG_AC3_AC4:      c_ac3_ac4 <= cfg_data;
        CFG_AC5_AC6:      c_ac5_ac6 <= cfg_data;
        CFG_B1_B2:        c_b1_b2   <= cfg_data;
        CFG_MC_MD:        c_mc_md   <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier, low 32 bits
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_T_X1:  begin mul_a = {16'd0, raw_r[15:0]} - ac6; mul_b = ac5; end
      OP_P_SQ:  begin mul_a = b6;  mul_b = b6; end
      OP_P_X1A: begin mul_a = b2;  mul_b = sq; end
      OP_P_X3A: begin mul_a = ac2; mul_b = b6; end
      OP_P_X1B: begin mul_a = ac3; mul_b = b6; end
      OP_P_X3B: begin mul_a = b1;  mul_b = sq; end
      OP_P_B4:  begin mul_a = ac4; mul_b = r1 + 32'd32768; end
      OP_P_B7:  begin mul_a = up - b3; mul_b = 32'd50000 >> oss; end
      OP_P_T:   begin mul_a = sra32(p, 5'd8); mul_b = sra32(p, 5'd8); end
      OP_P_X1C: begin mul_a = r1; mul_b = 32'd3038; end
      OP_P_FIN: begin mul_a = 32'(-32'sd7357); mul_b = p; end
      default:  ;
    endcase
  end
  assign prod = 32'(mul_a * mul_b);

  assign den_t = r1 + md;
  assign num_t = mc << 11;

  always_comb begin
    if (mode_r == MODE_PRESSURE) begin
      div_num   = prod[31] ? prod : (prod << 1);
      div_den   = b4;
      div_start = (cmd.op == OP_P_B7) && (b4 != 32'd0);
    end else begin
      div_num   = num_t[31] ? (32'd0 - num_t) : num_t;
      div_den   = den_t[31] ? (32'd0 - den_t) : den_t;
      div_start = (cmd.op == OP_T_DEN) && (den_t != 32'd0);
    end
  end

  ptc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign x2_t = tfault ? 32'd0 : (neg ? (32'd0 - quo) : quo);
  assign b5_t = r1 + x2_t;

  assign status.den_zero = (mode_r == MODE_PRESSURE) ? (b4 == 32'd0) : (den_t == 32'd0);
  assign status.div_done = div_done;
  assign status.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) last_b5 <= '0;
    else if (cmd.op == OP_T_FIN) last_b5 <= b5_t;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:  begin mode_r <= in_data.mode; raw_r <= in_data.raw_reading; end
      OP_T_X1:  r1 <= sra32(prod, 5'd15);
      OP_T_DEN: begin tfault <= (den_t == 32'd0); neg <= num_t[31] ^ den_t[31]; end
      OP_P_B6:  begin
        b6 <= last_b5 - 32'd4000;
        up <= {8'd0, raw_r >> (4'd8 - {2'b00, oss})};
      end
      OP_P_SQ:  sq <= sra32(prod, 5'd12);
      OP_P_X1A: r1 <= sra32(prod, 5'd11);
      OP_P_X3A: r1 <= r1 + sra32(prod, 5'd11);
      OP_P_B3:  b3 <= sra32((((ac1 << 2) + r1) << oss) + 32'd2, 5'd2);
      OP_P_X1B: r1 <= sra32(prod, 5'd13);
      OP_P_X3B: r1 <= sra32(r1 + sra32(prod, 5'd16) + 32'd2, 5'd2);
      OP_P_B4:  b4 <= prod >> 15;
      OP_P_B7:  post_shift <= prod[31];
      OP_P_P:   p <= post_shift ? (quo << 1) : quo;
      OP_P_T:   r1 <= prod;
      OP_P_X1C: r1 <= sra32(prod, 5'd16);
      default:  ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_T_FIN || cmd.op == OP_P_FIN || cmd.op == OP_P_FLT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_T_FIN: begin
        out_data.kind         <= MODE_TEMPERATURE;
        out_data.divide_fault <= tfault;
        out_data.value        <= tfault ? 32'sd0 : $signed(sra32(b5_t + 32'd8, 5'd4));
      end
      OP_P_FIN: begin
        out_data.kind         <= MODE_PRESSURE;
        out_data.divide_fault <= 1'b0;
        out_data.value        <= $signed(p + sra32(r1 + sra32(prod, 5'd16) + 32'd3791, 5'd4));
      end
      OP_P_FLT: begin
        out_data.kind         <= MODE_PRESSURE;
        out_data.divide_fault <= 1'b1;
        out_data.value        <= 32'sd0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/pressure_temperature_compensation_top.sv
// Top level of the barometric compensation block: sequencer plus datapath.
// Depends on ptc_pkg, ptc_ctrl, ptc_datapath.
//
// Turns raw sensor readings into calibrated values. A temperature item (mode
// 0) uses bits 15..0 of raw_reading, yields temperature in 0.1 degree steps
// and keeps the intermediate B5 for later pressure items; a pressure item
// (mode 1) is shifted right by 8 minus the oversampling setting and
// compensated with the stored B5 to give pascals. Arithmetic is 32-bit two's
// complement and wraps. When a divisor is zero, value is 0 and divide_fault
// is set (a temperature item still updates B5). One item is worked on at a
// time, and most of that time goes to the bit-serial divider; a pressure item
// whose divisor is zero skips the divider. The next item is taken as soon as
// the previous result sits in the output register, even while that result is
// still stalled. Write configuration only while the block is idle.
`default_nettype none

module pressure_temperature_compensation_top
  import ptc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write_en,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output out_item_t                     out_data
);

  ptc_cmd_t    cmd;
  ptc_status_t status;

  // sequence the steps of one item
  ptc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // hold coefficients, compute and present the result item
  ptc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

`default_nettype wire

FILE: design/ptc_checker.sv
// Port-level checks for the compensation block, bound to its top level.
// Depends on ptc_pkg.
`default_nettype none

module ptc_checker
  import ptc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in progress");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_fault |-> out_data.value == 32'sd0)
    else $error("faulted item carries a nonzero value");

endmodule

bind pressure_temperature_compensation_top ptc_checker u_ptc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
